[sv/bprg_pkg.sv]
`default_nettype none

package bprg_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [14:0] LCG_MUL = 15'd16807;
	localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	localparam int DIV_W = 62;
	localparam int DIVR_W = 31;
	localparam int LOG_W = 37;
	localparam int SH_W = 25;
	localparam int MAG_W = 53;

	localparam int QDEPTH = 2;

	localparam logic [1:0] CFG_ALPHA = 2'd0;
	localparam logic [1:0] CFG_K = 2'd1;
	localparam logic [1:0] CFG_P = 2'd2;

	localparam logic [23:0] ALPHA_RST = 24'd98304;
	localparam logic [31:0] K_RST = 32'd65536;
	localparam logic [31:0] P_RST = 32'd6553600;

	typedef struct packed {
		logic        skip;
		logic        err;
		logic [30:0] state;
	} job_t;

	typedef struct packed {
		logic [29:0]            fr;
		logic signed [SH_W-1:0] sh;
	} exp_arg_t;

	function automatic exp_arg_t exp_split(input logic neg, input logic [MAG_W-1:0] mag,
			input logic signed [SH_W-1:0] extra);
		logic [23:0] ip;
		logic [29:0] fr;
		exp_arg_t r;
		ip = {1'b0, mag[52:30]};
		fr = mag[29:0];
		if (neg) begin
			if (fr != 30'd0) begin
				ip = ip + 24'd1;
				fr = 30'(ONE_Q30 - {1'b0, fr});
			end
			r.sh = extra - $signed({1'b0, ip});
		end else begin
			r.sh = extra + $signed({1'b0, ip});
		end
		r.fr = fr;
		return r;
	endfunction

	function automatic logic [31:0] place(input logic [31:0] mant,
			input logic signed [SH_W-1:0] sh);
		logic [63:0] v;
		logic [SH_W-1:0] kk;
		logic [5:0] ks;
		logic [31:0] r;
		v = 64'd0;
		kk = '0;
		ks = 6'd0;
		if (sh >= 0) begin
			if (sh >= 25'sd32) begin
				r = (mant != 32'd0) ? SAT32 : 32'd0;
			end else begin
				v = {32'd0, mant} << sh[4:0];
				r = (v[63:32] != 32'd0) ? SAT32 : v[31:0];
			end
		end else begin
			kk = SH_W'(-sh);
			if (kk > SH_W'(62)) begin
				r = 32'd0;
			end else begin
				ks = kk[5:0];
				v = ({32'd0, mant} + (64'd1 << (ks - 6'd1))) >> ks;
				r = (v[63:32] != 32'd0) ? SAT32 : v[31:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/bprg_front.sv]
`default_nettype none

module bprg_front
	import bprg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        kind,
	input  wire logic [30:0] seed_value,
	input  wire logic [31:0] k_lower,
	input  wire logic [31:0] p_upper,
	input  wire logic        q_full,
	output logic             push,
	output job_t             push_job
);

	logic [30:0] state_q;
	logic [45:0] prod;
	logic [31:0] fold;
	logic [31:0] fold_red;
	logic [30:0] next_state;
	logic        err;

	assign item_ready = !q_full;
	assign push = item_valid && item_ready;

	always_comb begin
		prod = 46'(state_q) * 46'(LCG_MUL);
		fold = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
		fold_red = (fold >= {1'b0, LCG_MOD}) ? fold - {1'b0, LCG_MOD} : fold;
		if (kind) begin
			next_state = fold_red[30:0];
		end else if (seed_value != 31'd0 && seed_value != LCG_MOD) begin
			next_state = seed_value;
		end else begin
			next_state = state_q;
		end
		err = p_upper <= k_lower;
		push_job.skip = !kind || err || (k_lower == 32'd0);
		push_job.err = err;
		push_job.state = next_state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 31'd1;
		end else if (push) begin
			state_q <= next_state;
		end
	end

endmodule

`default_nettype wire

[sv/bprg_queue.sv]
`default_nettype none

module bprg_queue
	import bprg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      empty
);

	job_t       mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'(QDEPTH);
	assign empty = count_q == 2'd0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/bprg_div.sv]
`default_nettype none

module bprg_div
	import bprg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  dividend,
	input  wire logic [DIVR_W-1:0] divisor,
	output logic                   done,
	output logic [DIV_W-1:0]       quotient
);

	logic [DIV_W-1:0]  quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   r2;
	logic              ge;

	assign done = done_q;
	assign quotient = quo_q;

	always_comb begin
		r2 = {rem_q, quo_q[DIV_W-1]};
		ge = r2 >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? DIVR_W'(r2 - {1'b0, dvs_q}) : r2[DIVR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[sv/bprg_back.sv]
`default_nettype none

module bprg_back
	import bprg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  job_t             q_head,
	output logic             pop,
	input  wire logic [23:0] alpha_shape,
	input  wire logic [31:0] k_lower,
	input  wire logic [31:0] p_upper,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      sample,
	output logic [30:0]      uniform_state,
	output logic             config_error
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_NORM = 5'd1;
	localparam logic [4:0] S_SQ = 5'd2;
	localparam logic [4:0] S_SQ_USE = 5'd3;
	localparam logic [4:0] S_LOG_END = 5'd4;
	localparam logic [4:0] S_AL0 = 5'd5;
	localparam logic [4:0] S_AL1 = 5'd6;
	localparam logic [4:0] S_AL2 = 5'd7;
	localparam logic [4:0] S_EU = 5'd8;
	localparam logic [4:0] S_EU2 = 5'd9;
	localparam logic [4:0] S_ET = 5'd10;
	localparam logic [4:0] S_ET2 = 5'd11;
	localparam logic [4:0] S_ET3 = 5'd12;
	localparam logic [4:0] S_PLACE = 5'd13;
	localparam logic [4:0] S_D = 5'd14;
	localparam logic [4:0] S_D2 = 5'd15;
	localparam logic [4:0] S_DIV = 5'd16;
	localparam logic [4:0] S_DONE = 5'd17;

	localparam logic [1:0] L_K = 2'd0;
	localparam logic [1:0] L_P = 2'd1;
	localparam logic [1:0] L_D = 2'd2;

	localparam logic E_T = 1'b0;
	localparam logic E_Y = 1'b1;

	logic [4:0]  st_q;
	logic [1:0]  lph_q;
	logic        eph_q;

	logic [30:0] x_q;
	logic [31:0] w_q;
	logic [4:0]  e_q;
	logic [30:0] m_q;
	logic [29:0] frac_q;
	logic [4:0]  cnt_q;
	logic signed [LOG_W-1:0] lk_q;
	logic [35:0] nl_q;
	logic [41:0] acc_q;
	logic signed [SH_W-1:0] s_q;
	logic [29:0] efr_q;
	logic [29:0] u_q;
	logic [31:0] v_q;
	logic [30:0] term_q;
	logic [31:0] sum_q;
	logic [3:0]  n_q;
	logic [30:0] omt_q;
	logic [31:0] smp_q;
	logic [63:0] prod_q;

	logic        res_valid_q;
	logic [31:0] sample_q;
	logic [30:0] ustate_q;
	logic        err_out_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [23:0] a_eff;
	logic        out_free;
	logic signed [LOG_W-1:0] lres;
	logic signed [LOG_W-1:0] ldiff;
	logic [LOG_W-1:0] nd;
	logic [31:0] sq;
	logic [59:0] full_prod;
	logic [31:0] placed;
	logic [30:0] tclip;
	logic [31:0] lo_sum;
	logic [30:0] uni_quo;
	logic [30:0] dval;
	logic [30:0] tq;
	logic signed [MAG_W-1:0] ysum;
	logic [MAG_W-1:0] ymag;
	exp_arg_t    ea_t;
	exp_arg_t    ea_y;

	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [DIVR_W-1:0]   div_divisor;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;

	function automatic logic [31:0] recip_n(input logic [3:0] n);
		logic [31:0] r;
		case (n)
			4'd2: r = 32'd2147483648;
			4'd3: r = 32'd1431655766;
			4'd4: r = 32'd1073741824;
			4'd5: r = 32'd858993460;
			4'd6: r = 32'd715827883;
			4'd7: r = 32'd613566757;
			4'd8: r = 32'd536870912;
			4'd9: r = 32'd477218589;
			4'd10: r = 32'd429496730;
			4'd11: r = 32'd390451573;
			4'd12: r = 32'd357913942;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	bprg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign a_eff = (alpha_shape == 24'd0) ? 24'd1 : alpha_shape;
	assign out_free = !res_valid_q || result_ready;
	assign pop = (st_q == S_IDLE) && !q_empty && (out_free || !q_head.skip);

	assign result_valid = res_valid_q;
	assign sample = sample_q;
	assign uniform_state = ustate_q;
	assign config_error = err_out_q;

	always_comb begin
		lres = $signed({2'b00, e_q, frac_q})
			- ((lph_q == L_D) ? $signed({7'd30, 30'd0}) : $signed({7'(FRAC_BITS), 30'd0}));
		ldiff = lres - lk_q;
		nd = LOG_W'(-lres);
		sq = prod_q[61:30];
		full_prod = {18'd0, acc_q} + {prod_q[41:0], 18'd0};
		ea_t = exp_split(1'b1, MAG_W'(full_prod >> FRAC_BITS), '0);
		placed = place(sum_q, s_q);
		tclip = (placed > 32'(ONE_Q30)) ? ONE_Q30 : placed[30:0];
		lo_sum = {1'b0, prod_q[30:0]} + {1'b0, prod_q[61:31]};
		uni_quo = prod_q[61:31] + 31'(lo_sum >= {1'b0, LCG_MOD});
		dval = ONE_Q30 - uni_quo;
		if (dval == 31'd0) begin
			dval = 31'd1;
		end
		tq = (n_q == 4'd1) ? v_q[30:0] : prod_q[62:32];
		ysum = MAG_W'(lk_q) + $signed({2'b00, div_quo[50:0]});
		ymag = (ysum < 0) ? MAG_W'(-ysum) : MAG_W'(ysum);
		ea_y = exp_split(ysum < 0, ymag, SH_W'(FRAC_BITS - 30));

		mul_a = 32'd0;
		mul_b = 32'd0;
		case (st_q)
			S_SQ: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			S_AL0: begin
				mul_a = {8'd0, a_eff};
				mul_b = {14'd0, nl_q[17:0]};
			end
			S_AL1: begin
				mul_a = {8'd0, a_eff};
				mul_b = {14'd0, nl_q[35:18]};
			end
			S_EU: begin
				mul_a = {2'd0, efr_q};
				mul_b = {2'd0, LN2_Q30};
			end
			S_ET: begin
				mul_a = {1'b0, term_q};
				mul_b = {2'd0, u_q};
			end
			S_ET2: begin
				mul_a = prod_q[61:30];
				mul_b = recip_n(n_q);
			end
			S_D: begin
				mul_a = {1'b0, x_q};
				mul_b = {1'b0, omt_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase

		div_start = (st_q == S_LOG_END) && (lph_q == L_D);
		div_dividend = DIV_W'(nd[34:0]) << FRAC_BITS;
		div_divisor = DIVR_W'(a_eff);
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (st_q)
			S_IDLE: begin
				x_q <= q_head.state;
				w_q <= k_lower;
				e_q <= 5'd31;
			end
			S_NORM: begin
				if (w_q[31]) begin
					m_q <= w_q[31:1];
					frac_q <= 30'd0;
					cnt_q <= 5'd0;
				end else begin
					w_q <= {w_q[30:0], 1'b0};
					e_q <= e_q - 5'd1;
				end
			end
			S_SQ_USE: begin
				if (sq[31]) begin
					m_q <= sq[31:1];
					frac_q <= {frac_q[28:0], 1'b1};
				end else begin
					m_q <= sq[30:0];
					frac_q <= {frac_q[28:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
			end
			S_LOG_END: begin
				if (lph_q == L_K) begin
					lk_q <= lres;
					w_q <= p_upper;
					e_q <= 5'd31;
				end
				nl_q <= (ldiff > 0) ? ldiff[35:0] : 36'd0;
			end
			S_AL1: begin
				acc_q <= prod_q[41:0];
			end
			S_AL2: begin
				s_q <= ea_t.sh;
				efr_q <= ea_t.fr;
			end
			S_EU2: begin
				u_q <= prod_q[59:30];
				term_q <= ONE_Q30;
				sum_q <= 32'(ONE_Q30);
				n_q <= 4'd1;
			end
			S_ET2: begin
				v_q <= prod_q[61:30];
			end
			S_ET3: begin
				term_q <= tq;
				sum_q <= sum_q + 32'(tq);
				n_q <= n_q + 4'd1;
			end
			S_PLACE: begin
				omt_q <= ONE_Q30 - tclip;
				smp_q <= placed;
			end
			S_D2: begin
				w_q <= {1'b0, dval};
				e_q <= 5'd31;
			end
			S_DIV: begin
				if (div_done) begin
					s_q <= ea_y.sh;
					efr_q <= ea_y.fr;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && pop && q_head.skip) begin
			sample_q <= 32'd0;
			ustate_q <= q_head.state;
			err_out_q <= q_head.err;
		end else if (st_q == S_DONE && out_free) begin
			sample_q <= smp_q;
			ustate_q <= x_q;
			err_out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			lph_q <= L_K;
			eph_q <= E_T;
			res_valid_q <= 1'b0;
		end else begin
			if ((st_q == S_IDLE && pop && q_head.skip) || (st_q == S_DONE && out_free)) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (pop && !q_head.skip) begin
						lph_q <= L_K;
						st_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (w_q[31]) begin
						st_q <= S_SQ;
					end
				end
				S_SQ: begin
					st_q <= S_SQ_USE;
				end
				S_SQ_USE: begin
					st_q <= (cnt_q == 5'd29) ? S_LOG_END : S_SQ;
				end
				S_LOG_END: begin
					case (lph_q)
						L_K: begin
							lph_q <= L_P;
							st_q <= S_NORM;
						end
						L_P: begin
							st_q <= S_AL0;
						end
						default: begin
							st_q <= S_DIV;
						end
					endcase
				end
				S_AL0: begin
					st_q <= S_AL1;
				end
				S_AL1: begin
					st_q <= S_AL2;
				end
				S_AL2: begin
					eph_q <= E_T;
					st_q <= S_EU;
				end
				S_EU: begin
					st_q <= S_EU2;
				end
				S_EU2: begin
					st_q <= S_ET;
				end
				S_ET: begin
					st_q <= S_ET2;
				end
				S_ET2: begin
					st_q <= S_ET3;
				end
				S_ET3: begin
					st_q <= (n_q == 4'd12) ? S_PLACE : S_ET;
				end
				S_DIV: begin
					if (div_done) begin
						eph_q <= E_Y;
						st_q <= S_EU;
					end
				end
				S_PLACE: begin
					st_q <= (eph_q == E_T) ? S_D : S_DONE;
				end
				S_D: begin
					st_q <= S_D2;
				end
				S_D2: begin
					lph_q <= L_D;
					st_q <= S_NORM;
				end
				S_DONE: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/bounded_pareto_random_generator.sv]
// Bounded Pareto sample generator driven by a minimal-standard LCG.
// Input channel (item_valid/item_ready) takes one word: kind 0 loads
// seed_value into the generator state unless it is 0 or 2^31-1, kind 1
// steps the generator and draws one sample. Every word yields exactly one
// result word on the result channel (result_valid/result_ready) in input order.
// Configuration registers (alpha, k, p) are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is idle,
// as the block does not enforce it. The front steps the generator at one
// word per cycle unless the queue is full and sorts words into those that
// need the transform and those that do not; a two-entry queue separates it
// from the transform engine. Seed words and draws with bad bounds or a zero
// k pass through the queue and the output register and flow at one per
// cycle while the engine is idle and the receiver takes them. A draw runs
// longer for each leading zero of k, of p and of the Q.30 value
// 1 - z*(1-(k/p)^alpha) in a 32-bit word. Its length is set by the 30
// squaring steps of each of three logarithms on the shared multiplier, the
// 62-step serial divide by alpha, and the series terms of both exponentials.
// Reset loads the generator state with one and the registers with
// alpha 1.5, k 1.0 and p 100.0. When the receiver stalls, the result
// waits in the output register and the queue fills before item_ready drops.
`default_nettype none

module bounded_pareto_random_generator
	import bprg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        kind,
	input  wire logic [30:0] seed_value,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      sample,
	output logic [30:0]      uniform_state,
	output logic             config_error,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [23:0] alpha_q;
	logic [31:0] k_q;
	logic [31:0] p_q;
	logic        push;
	job_t        push_job;
	logic        pop;
	job_t        head;
	logic        q_full;
	logic        q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			k_q <= K_RST;
			p_q <= P_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALPHA: alpha_q <= cfg_data[23:0];
				CFG_K: k_q <= cfg_data;
				CFG_P: p_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bprg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.kind       (kind),
		.seed_value (seed_value),
		.k_lower    (k_q),
		.p_upper    (p_q),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	bprg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	bprg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (head),
		.pop           (pop),
		.alpha_shape   (alpha_q),
		.k_lower       (k_q),
		.p_upper       (p_q),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.sample        (sample),
		.uniform_state (uniform_state),
		.config_error  (config_error)
	);

endmodule

`default_nettype wire

[sv/bprg_checker.sv]
`default_nettype none

module bprg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [31:0] sample,
	input wire logic [30:0] uniform_state,
	input wire logic        config_error
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(sample)
			&& $stable(uniform_state) && $stable(config_error))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && config_error |-> sample == 32'd0)
		else $error("bad bounds gave a nonzero sample");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> uniform_state != 31'd0 && uniform_state != 31'h7FFF_FFFF)
		else $error("generator state left its cycle");

endmodule

bind bounded_pareto_random_generator bprg_checker u_bprg_checker (.*);

`default_nettype wire

[tb/bounded_pareto_random_generator_tb.sv]
`default_nettype none

module bounded_pareto_random_generator_tb;
	import bprg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_DRAW = 1'b1;
	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 85;
	localparam longint unsigned Q30 = 64'd1073741824;

	typedef struct {
		logic        sample_known;
		logic [31:0] sample;
		logic [30:0] state;
		logic        err;
	} outcome_t;

	typedef struct {
		logic        is_write;
		logic [1:0]  index;
		logic [31:0] data;
		logic        kind;
		logic [30:0] seed;
		logic        known;
		logic [31:0] sample;
		logic [30:0] state;
		logic        err;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        kind = 1'b0;
	logic [30:0] seed_value = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] sample;
	logic [30:0] uniform_state;
	logic        config_error;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_ALPHA;
	logic [31:0] cfg_data = '0;

	bounded_pareto_random_generator dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [23:0] m_alpha;
	logic [31:0] m_k;
	logic [31:0] m_p;
	logic [30:0] m_state;
	outcome_t    pending[$];
	row_t        script[$];
	int          fails = 0;
	int          draws = 0;
	int          seeds = 0;
	int          err_words = 0;
	int          burst_left = 0;
	logic        steady_rx = 1'b0;

	function automatic longint signed log2_q30(longint unsigned v, int fb);
		int e;
		longint unsigned m;
		longint unsigned frac;
		e = 63;
		frac = 0;
		while (e > 0 && v[e] == 1'b0)
			e--;
		if (e > 30)
			m = v >> (e - 30);
		else
			m = v << (30 - e);
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 2 * Q30) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		return (longint'(e) - longint'(fb)) * longint'(Q30) + longint'(frac);
	endfunction

	function automatic longint unsigned pow2_series(longint unsigned f);
		longint unsigned u;
		longint unsigned term;
		longint unsigned sum;
		u = (f * longint'(LN2_Q30)) >> 30;
		term = Q30;
		sum = Q30;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * u) >> 30) / n;
			sum += term;
		end
		return sum;
	endfunction

	function automatic logic [31:0] scale_q(longint unsigned mant, longint signed s);
		longint unsigned v;
		longint signed sr;
		if (s >= 0) begin
			if (s >= 32)
				return (mant != 0) ? SAT32 : 32'd0;
			v = mant << s;
		end else begin
			sr = -s;
			if (sr > 62)
				return 32'd0;
			v = (mant + (64'd1 << (sr - 1))) >> sr;
		end
		return (v > 64'hFFFF_FFFF) ? SAT32 : v[31:0];
	endfunction

	function automatic logic [31:0] pow2_q(logic neg, longint unsigned mag, longint signed extra);
		longint signed ip;
		longint unsigned fr;
		longint signed s;
		ip = longint'(mag >> 30);
		fr = mag & (Q30 - 1);
		if (neg) begin
			if (fr != 0) begin
				ip += 1;
				fr = Q30 - fr;
			end
			s = extra - ip;
		end else begin
			s = extra + ip;
		end
		return scale_q(pow2_series(fr), s);
	endfunction

	function automatic logic [31:0] pareto_of(longint unsigned x);
		longint signed lk, lp, ld, y;
		longint unsigned a, nl, ex, t, d, nd, q;
		if (m_k == 0)
			return 32'd0;
		lk = log2_q30(m_k, FRAC_BITS);
		lp = log2_q30(m_p, FRAC_BITS);
		nl = (lp > lk) ? longint'(lp - lk) : 0;
		a = (m_alpha != 0) ? m_alpha : 1;
		ex = (a * nl) >> FRAC_BITS;
		t = pow2_q(1'b1, ex, 0);
		if (t > Q30)
			t = Q30;
		d = Q30 - (x * (Q30 - t)) / longint'(LCG_MOD);
		if (d == 0)
			d = 1;
		ld = log2_q30(d, 30);
		nd = (ld < 0) ? longint'(-ld) : 0;
		q = (nd << FRAC_BITS) / a;
		y = lk + longint'(q);
		if (y >= 0)
			return pow2_q(1'b0, y, FRAC_BITS - 30);
		return pow2_q(1'b1, -y, FRAC_BITS - 30);
	endfunction

	function automatic outcome_t advance_generator(logic k_in, logic [30:0] s_in);
		outcome_t o;
		o.sample_known = 1'b1;
		o.err = (m_p <= m_k);
		o.sample = 32'd0;
		if (k_in == KIND_SEED) begin
			if (s_in != 31'd0 && s_in != LCG_MOD)
				m_state = s_in;
		end else begin
			m_state = 31'((64'(m_state) * LCG_MUL) % LCG_MOD);
			if (!o.err)
				o.sample = pareto_of(m_state);
		end
		o.state = m_state;
		return o;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		item_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ALPHA: m_alpha = val[23:0];
			CFG_K: m_k = val;
			CFG_P: m_p = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(logic k_in, logic [30:0] s_in, logic known, outcome_t typed);
		outcome_t o;
		item_valid <= 1'b1;
		kind <= k_in;
		seed_value <= s_in;
		do @(posedge clk); while (!item_ready);
		o = advance_generator(k_in, s_in);
		if (known) begin
			if (o.sample != typed.sample || o.state != typed.state || o.err != typed.err)
				$error("typed-in row disagrees with prediction: sample %h state %h err %b",
					typed.sample, typed.state, typed.err);
			o = typed;
		end
		pending.push_back(o);
		if (k_in == KIND_DRAW)
			draws++;
		else
			seeds++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		end
	endtask

	task automatic add_write(logic [1:0] idx, logic [31:0] val);
		row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.index = idx;
		r.data = val;
		script.push_back(r);
	endtask

	task automatic add_word(logic k_in, logic [30:0] s_in, logic known = 1'b0,
			logic [31:0] smp = 0, logic [30:0] st = 0, logic er = 0);
		row_t r;
		r = '{default: '0};
		r.kind = k_in;
		r.seed = s_in;
		r.known = known;
		r.sample = smp;
		r.state = st;
		r.err = er;
		script.push_back(r);
	endtask

	always @(posedge clk) begin
		outcome_t o;
		if (result_valid && result_ready) begin
			if (pending.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				o = pending.pop_front();
				if (sample !== o.sample) begin
					$error("sample: expected %h, got %h", o.sample, sample);
					fails++;
				end
				if (uniform_state !== o.state) begin
					$error("uniform_state: expected %h, got %h", o.state, uniform_state);
					fails++;
				end
				if (config_error !== o.err) begin
					$error("config_error: expected %b, got %b", o.err, config_error);
					fails++;
				end
				if (o.err)
					err_words++;
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (steady_rx) begin
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 12);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	int quiet = 0;
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		row_t r;
		outcome_t typed;
		logic [31:0] kv;
		m_alpha = ALPHA_RST;
		m_k = K_RST;
		m_p = P_RST;
		m_state = 31'd1;

		add_word(KIND_DRAW, 31'd0, 1'b0);
		add_word(KIND_SEED, 31'd0, 1'b1, 32'd0, 31'd16807, 1'b0);
		add_word(KIND_SEED, 31'h7FFF_FFFF, 1'b1, 32'd0, 31'd16807, 1'b0);
		add_word(KIND_SEED, 31'd2147483646, 1'b1, 32'd0, 31'd2147483646, 1'b0);
		add_word(KIND_DRAW, 31'h5555_5555);
		add_word(KIND_SEED, 31'd1, 1'b1, 32'd0, 31'd1, 1'b0);
		add_word(KIND_DRAW, 31'h2AAA_AAAA);
		add_write(CFG_P, 32'd65536);
		add_word(KIND_SEED, 31'd1, 1'b1, 32'd0, 31'd1, 1'b1);
		add_word(KIND_DRAW, 31'd0, 1'b1, 32'd0, 31'd16807, 1'b1);
		add_word(KIND_SEED, 31'd5, 1'b1, 32'd0, 31'd5, 1'b1);
		add_write(CFG_K, 32'd0);
		add_write(CFG_P, 32'd1);
		add_word(KIND_DRAW, 31'd0, 1'b1, 32'd0, 31'd84035, 1'b0);
		add_write(CFG_ALPHA, 32'd0);
		add_write(CFG_K, K_RST);
		add_write(CFG_P, P_RST);
		add_word(KIND_DRAW, 31'd0);
		add_write(CFG_ALPHA, 32'h00FF_FFFF);
		add_word(KIND_DRAW, 31'd0);
		add_write(CFG_ALPHA, 32'd1);
		add_word(KIND_DRAW, 31'd0);
		add_write(CFG_K, 32'd1);
		add_write(CFG_P, 32'hFFFF_FFFF);
		add_word(KIND_DRAW, 31'd0);
		add_write(CFG_K, 32'hFFFF_FFFE);
		add_word(KIND_DRAW, 31'd0);
		add_write(CFG_ALPHA, ALPHA_RST);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			r = script[i];
			if (r.is_write) begin
				write_reg(r.index, r.data);
			end else begin
				typed.sample_known = 1'b1;
				typed.sample = r.sample;
				typed.state = r.state;
				typed.err = r.err;
				send_word(r.kind, r.seed, r.known, typed);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			steady_rx = (ph % 4 == 3);
			case ($urandom_range(0, 3))
				0: write_reg(CFG_ALPHA, 32'd1);
				1: write_reg(CFG_ALPHA, 32'h00FF_FFFF);
				2: write_reg(CFG_ALPHA, $urandom_range(1, 32'h0008_0000));
				default: write_reg(CFG_ALPHA, $urandom_range(0, 32'h00FF_FFFF));
			endcase
			case ($urandom_range(0, 4))
				0: begin
					kv = $urandom;
					write_reg(CFG_K, kv);
					write_reg(CFG_P, $urandom_range(0, kv));
				end
				1: begin
					write_reg(CFG_K, $urandom);
					write_reg(CFG_P, $urandom);
				end
				default: begin
					kv = $urandom_range(1, 32'h0010_0000);
					write_reg(CFG_K, kv);
					write_reg(CFG_P, kv + $urandom_range(1, 32'h1000_0000));
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				typed = '{default: '0};
				case ($urandom_range(0, 19))
					0: send_word(KIND_SEED, 31'd0, 1'b0, typed);
					1: send_word(KIND_SEED, 31'h7FFF_FFFF, 1'b0, typed);
					2, 3, 4, 5, 6, 7, 8:
						send_word(KIND_SEED, 31'($urandom), 1'b0, typed);
					default: send_word(KIND_DRAW, 31'($urandom), 1'b0, typed);
				endcase
			end
		end

		item_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (2500) @(posedge clk);
		$display("Covered %0d draw words and %0d seed words, %0d of them with bad bounds,",
			draws, seeds, err_words);
		$display("over the directed rows and %0d random register settings.", RANDOM_PHASES);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
